// ===== src/mte_pkg.sv =====
// shared types, constants and the character lookup for the morse text encoder
// no dependencies
`default_nettype none

package mte_pkg;

   localparam int CHAR_W = 8;
   localparam int IDX_W  = 7;
   localparam int CNT_W  = 3;

   localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHR_DASH  = 8'h5F;
   localparam logic [CHAR_W-1:0] CHR_LOW_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHR_LOW_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFS  = 8'h20;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SLASH,
      S_CODE,
      S_GAP
   } state_type;

   typedef enum logic [1:0] {
      KIND_DROP,
      KIND_SPACE,
      KIND_CODE
   } kind_type;

   typedef enum logic [1:0] {
      SYM_SLASH,
      SYM_CODE,
      SYM_GAP
   } sym_sel_type;

   typedef struct packed {
      logic        load;
      logic        emit;
      logic        shift;
      sym_sel_type sel;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     cnt_one;
      logic     out_free;
   } status_type;

   // heap index of a character (letters in uppercase), zero when absent
   function automatic logic [IDX_W-1:0] heap_index(input logic [CHAR_W-1:0] c);
      logic [IDX_W-1:0] r;
      unique case (c)
         "E":  r = 7'd2;
         "T":  r = 7'd3;
         "I":  r = 7'd4;
         "A":  r = 7'd5;
         "N":  r = 7'd6;
         "M":  r = 7'd7;
         "S":  r = 7'd8;
         "U":  r = 7'd9;
         "R":  r = 7'd10;
         "W":  r = 7'd11;
         "D":  r = 7'd12;
         "K":  r = 7'd13;
         "G":  r = 7'd14;
         "O":  r = 7'd15;
         "H":  r = 7'd16;
         "V":  r = 7'd17;
         "F":  r = 7'd18;
         "L":  r = 7'd20;
         "P":  r = 7'd22;
         "J":  r = 7'd23;
         "B":  r = 7'd24;
         "X":  r = 7'd25;
         "C":  r = 7'd26;
         "Y":  r = 7'd27;
         "Z":  r = 7'd28;
         "Q":  r = 7'd29;
         "5":  r = 7'd32;
         "4":  r = 7'd33;
         "2":  r = 7'd39;
         "+":  r = 7'd42;
         "1":  r = 7'd47;
         "6":  r = 7'd48;
         "=":  r = 7'd49;
         "/":  r = 7'd50;
         "(":  r = 7'd54;
         "7":  r = 7'd56;
         "8":  r = 7'd60;
         "9":  r = 7'd62;
         "0":  r = 7'd63;
         "?":  r = 7'd76;
         "_":  r = 7'd77;
         8'h22: r = 7'd82;
         ".":  r = 7'd85;
         "@":  r = 7'd90;
         8'h27: r = 7'd94;
         "-":  r = 7'd97;
         ";":  r = 7'd106;
         "!":  r = 7'd107;
         ")":  r = 7'd109;
         ",":  r = 7'd115;
         ":":  r = 7'd120;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/mte_dp.sv =====
// datapath: character fold and lookup, code shift register, output beat register
// depends on mte_pkg
`default_nettype none

module mte_dp
   import mte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CHAR_W-1:0] char_in,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic              rsp_tready,
   output logic                   rsp_tvalid,
   output logic [CHAR_W-1:0]      rsp_tdata,
   output logic                   rsp_tlast
);

   logic [CHAR_W-1:0] fold;
   logic [IDX_W-1:0]  idx;
   logic [CNT_W-1:0]  top;
   logic [IDX_W-2:0]  aligned;
   logic [CHAR_W-1:0] sym;

   logic              prev_ff, prev_in;
   logic [IDX_W-2:0]  code_ff, code_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] sym_ff, sym_in;
   logic              last_ff, last_in;

   always_comb begin
      fold = char_in;
      if (char_in >= CHR_LOW_A && char_in <= CHR_LOW_Z) begin
         fold = char_in - CASE_OFS;
      end
      idx = heap_index(fold);
      top = '0;
      for (int b = 1; b < IDX_W; b++) begin
         if (idx[b]) begin
            top = CNT_W'(b);
         end
      end
      aligned = (IDX_W-1)'(idx << (CNT_W'(IDX_W - 1) - top));
   end

   always_comb begin
      status.out_free = !valid_ff || rsp_tready;
      status.cnt_one  = (cnt_ff == CNT_W'(1));
      if (fold == CHR_SPACE) begin
         status.kind = prev_ff ? KIND_DROP : KIND_SPACE;
      end else if (idx == '0) begin
         status.kind = KIND_DROP;
      end else begin
         status.kind = KIND_CODE;
      end
   end

   always_comb begin
      unique case (cmd.sel)
         SYM_SLASH: sym = CHR_SLASH;
         SYM_CODE:  sym = code_ff[IDX_W-2] ? CHR_DASH : CHR_DOT;
         SYM_GAP:   sym = CHR_SPACE;
         default:   sym = CHR_SPACE;
      endcase
   end

   always_comb begin
      prev_in  = prev_ff;
      code_in  = code_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      sym_in   = sym_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         prev_in = (fold == CHR_SPACE);
         code_in = aligned;
         cnt_in  = top;
      end
      if (cmd.shift) begin
         code_in = {code_ff[IDX_W-3:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
      end
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         sym_in   = sym;
         last_in  = (cmd.sel == SYM_GAP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
      cnt_ff  <= cnt_in;
      sym_ff  <= sym_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = sym_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== src/mte_ctrl.sv =====
// controller: sequences the symbols of one character
// depends on mte_pkg
`default_nettype none

module mte_ctrl
   import mte_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd.load   = 1'b0;
      cmd.emit   = 1'b0;
      cmd.shift  = 1'b0;
      cmd.sel    = SYM_GAP;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (status.kind)
                  KIND_SPACE: state_in = S_SLASH;
                  KIND_CODE:  state_in = S_CODE;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_SLASH: begin
            cmd.sel = SYM_SLASH;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_GAP;
            end
         end
         S_CODE: begin
            cmd.sel = SYM_CODE;
            if (status.out_free) begin
               cmd.emit  = 1'b1;
               cmd.shift = 1'b1;
               if (status.cnt_one) begin
                  state_in = S_GAP;
               end
            end
         end
         S_GAP: begin
            cmd.sel = SYM_GAP;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/morse_text_encoder.sv =====
// morse text encoder top level: controller and datapath
// depends on mte_pkg, mte_ctrl, mte_dp
//
// usage:
//   req_ channel takes one ascii character per beat (req_tdata). lowercase
//   letters are folded to uppercase. the rsp_ channel returns the morse text
//   one symbol per beat: '.' dot, '_' dash, ' ' gap, '/' word break, with
//   rsp_tlast high on the final symbol of the character.
//   a space gives '/' then ' '; further spaces in a run give nothing.
//   a character with no morse code gives nothing.
//   timing: a character is taken, then one symbol per cycle leaves the
//   controller while the output register is free. the character beat
//   loads the code register; the symbol state after it writes the first
//   symbol into the output register, which drives rsp_.
//   the output register lets the next character be taken while the last
//   symbol still waits. when the receiver stalls, the symbol sequencer
//   holds and req_tready stays low until the character is finished.
//   reset clears the run-of-spaces flag, the sequencer and rsp_tvalid.
`default_nettype none

module morse_text_encoder
   import mte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [CHAR_W-1:0] req_tdata,   // [7:0] char_in
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [CHAR_W-1:0]      rsp_tdata,   // [7:0] symbol
   output logic                   rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   mte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mte_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .char_in    (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
